@@ src/ppb_pkg.sv @@
// Shared types, register offsets and constants of the private peripheral bus block.
package ppb_pkg;

   localparam int IRQ_COUNT    = 32;
   localparam int HANDLER_CNT  = 3;
   localparam int TICK_WIDTH   = 24;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   // Register offsets inside the window
   localparam logic [19:0] OFS_SYST_CSR   = 20'hE010;
   localparam logic [19:0] OFS_SYST_RVR   = 20'hE014;
   localparam logic [19:0] OFS_SYST_CVR   = 20'hE018;
   localparam logic [19:0] OFS_SYST_CALIB = 20'hE01C;
   localparam logic [19:0] OFS_ISER       = 20'hE100;
   localparam logic [19:0] OFS_ICER       = 20'hE180;
   localparam logic [19:0] OFS_ISPR       = 20'hE200;
   localparam logic [19:0] OFS_ICPR       = 20'hE280;
   localparam logic [19:0] OFS_IPR_BASE   = 20'hE400;
   localparam logic [19:0] OFS_IPR_END    = 20'hE420;
   localparam logic [19:0] OFS_CPUID      = 20'hED00;
   localparam logic [19:0] OFS_ICSR       = 20'hED04;
   localparam logic [19:0] OFS_VTOR       = 20'hED08;
   localparam logic [19:0] OFS_AIRCR      = 20'hED0C;
   localparam logic [19:0] OFS_CCR        = 20'hED14;
   localparam logic [19:0] OFS_SHPR2      = 20'hED1C;
   localparam logic [19:0] OFS_SHPR3      = 20'hED20;

   // Fixed read values
   localparam logic [31:0] CPUID_VALUE    = 32'h410CC601;
   localparam logic [31:0] CALIB_VALUE    = 32'd124999;
   localparam logic [31:0] AIRCR_VALUE    = 32'hFA050000;
   localparam logic [31:0] CCR_VALUE      = 32'h00000200;
   localparam logic [15:0] AIRCR_KEY      = 16'h05FA;
   localparam logic [8:0]  IRQ_VECT_BASE  = 9'd16;

   // Pend flag and control bit positions
   localparam int FLAG_NMI    = 0;
   localparam int FLAG_PENDSV = 1;
   localparam int FLAG_TICK   = 2;
   localparam int CTRL_ENABLE = 0;
   localparam int CTRL_TICKINT = 1;
   localparam int CTRL_COUNT  = 3;

   typedef struct packed {
      opcode_type  opcode;
      logic [19:0] offset;
      logic [31:0] write_data;
      logic [31:0] line_levels;
      logic [8:0]  active_exception;
      logic [2:0]  pend_clear;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        nmi_pending;
      logic        pendsv_pending;
      logic        systick_pending;
      logic [31:0] irq_active_pending;
      logic        reset_request;
   } rsp_word_type;

endpackage

@@ src/ppb_req_if.sv @@
// Request channel: register access or SysTick reference tick words.
interface ppb_req_if;
   import ppb_pkg::*;

   logic        valid;
   logic        ready;
   opcode_type  opcode;
   logic [19:0] offset;
   logic [31:0] write_data;
   logic [31:0] line_levels;
   logic [8:0]  active_exception;
   logic [2:0]  pend_clear;

   modport source (
      output valid, opcode, offset, write_data, line_levels, active_exception, pend_clear,
      input  ready
   );
   modport sink (
      input  valid, opcode, offset, write_data, line_levels, active_exception, pend_clear,
      output ready
   );
endinterface

@@ src/ppb_rsp_if.sv @@
// Response channel: read data, pend flags and reset request words.
interface ppb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        nmi_pending;
   logic        pendsv_pending;
   logic        systick_pending;
   logic [31:0] irq_active_pending;
   logic        reset_request;

   modport source (
      output valid, read_data, nmi_pending, pendsv_pending, systick_pending,
             irq_active_pending, reset_request,
      input  ready
   );
   modport sink (
      input  valid, read_data, nmi_pending, pendsv_pending, systick_pending,
             irq_active_pending, reset_request,
      output ready
   );
endinterface

@@ src/armv6m_private_peripheral_bus_core.sv @@
// NVIC, SCB and SysTick register block of one ARMv6-M core.
//
// Usage: every request word is a register read, a register write, one SysTick
// reference tick or a no-op, along with the current interrupt line levels, the
// active exception number and the core's pend-clear acknowledges. Every
// request word produces exactly one response word holding the read data
// (zero for writes, ticks, no-ops and unmapped offsets), the NMI/PendSV/SysTick pend
// flags after the word, the enabled-and-pending interrupt lines and a
// one-word reset request pulse for a keyed AIRCR SYSRESETREQ write.
//
// Pipeline: a request word is captured in the request register, evaluated and
// presented on the response channel from the response register.
// Throughput: one word per cycle unless the response channel stalls; all register
// updates are a single pass of logic between the request and response registers.
//
// Stall: when the response register is full and not taken, the request
// register holds and ready drops once it is also full; no word is lost.
// Reset: synchronous, clears all architectural state and both valid bits; the
// reset request output only flags, it does not reset this block.
module armv6m_private_peripheral_bus_core (
   input logic        clock,
   input logic        reset,
   ppb_req_if.sink    req_chan,
   ppb_rsp_if.source  rsp_chan
);
   import ppb_pkg::*;

   // Pipeline registers
   logic         s1_valid_ff;
   req_word_type s1_ff;
   logic         out_valid_ff;
   rsp_word_type out_ff;
   rsp_word_type out_in;
   logic         advance;
   logic         req_accept;

   // Architectural state
   logic [31:0]           en_ff, en_in;
   logic [31:0]           soft_ff, soft_in;
   logic [7:0]            prio_ff [IRQ_COUNT];
   logic [7:0]            prio_in [IRQ_COUNT];
   logic [7:0]            hprio_ff [HANDLER_CNT];
   logic [7:0]            hprio_in [HANDLER_CNT];
   logic [24:0]           vtor_ff, vtor_in;
   logic [2:0]            pend_ff, pend_in;
   logic [3:0]            ctrl_ff, ctrl_in;
   logic [TICK_WIDTH-1:0] reload_ff, reload_in;
   logic [TICK_WIDTH-1:0] current_ff, current_in;
   logic [TICK_WIDTH-1:0] phase_ff, phase_in;

   // Handshake: advance the request register into the response register
   // whenever the response slot is free or being drained.
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.read_data          = out_ff.read_data;
   assign rsp_chan.nmi_pending        = out_ff.nmi_pending;
   assign rsp_chan.pendsv_pending     = out_ff.pendsv_pending;
   assign rsp_chan.systick_pending    = out_ff.systick_pending;
   assign rsp_chan.irq_active_pending = out_ff.irq_active_pending;
   assign rsp_chan.reset_request      = out_ff.reset_request;

   // Single-pass evaluation of the registered request word
   always_comb begin
      logic [31:0]           rd;
      logic                  rst_req;
      logic [31:0]           pend_lines;
      logic [255:0]          prio_flat;
      logic                  ipr_hit;
      logic [4:0]            ipr_base;
      logic [4:0]            low_idx;
      logic [5:0]            diff;
      logic [TICK_WIDTH-1:0] ph_inc;
      logic                  wrap;

      en_in      = en_ff;
      soft_in    = soft_ff;
      prio_in    = prio_ff;
      hprio_in   = hprio_ff;
      vtor_in    = vtor_ff;
      ctrl_in    = ctrl_ff;
      reload_in  = reload_ff;
      current_in = current_ff;
      phase_in   = phase_ff;
      rd         = 32'd0;
      rst_req    = 1'b0;
      diff       = 6'd0;

      // Core acknowledges drop pend flags before the operation
      pend_in = pend_ff & ~s1_ff.pend_clear;

      pend_lines = (s1_ff.line_levels | soft_ff) & en_ff;

      // Lowest pending line: scan down so the lowest set bit wins
      low_idx = 5'd31;
      for (int k = IRQ_COUNT - 1; k >= 0; k--) begin
         if (pend_lines[k]) begin
            low_idx = 5'(k);
         end
      end

      for (int k = 0; k < IRQ_COUNT; k++) begin
         prio_flat[k*8 +: 8] = prio_ff[k];
      end

      ipr_hit  = (s1_ff.offset >= OFS_IPR_BASE) && (s1_ff.offset < OFS_IPR_END);
      ipr_base = s1_ff.offset[4:0];

      ph_inc = phase_ff + TICK_WIDTH'(1);
      wrap   = ({1'b0, ph_inc} >= ({1'b0, reload_ff} + 25'd1)) || (ph_inc == '0);

      case (s1_ff.opcode)
         OP_READ: begin
            case (s1_ff.offset)
               OFS_SYST_CSR: begin
                  rd = {15'd0, ctrl_ff[CTRL_COUNT], 13'd0, ctrl_ff[2:0]};
                  ctrl_in[CTRL_COUNT] = 1'b0;
               end
               OFS_SYST_RVR:   rd = {8'd0, reload_ff};
               OFS_SYST_CVR:   rd = {8'd0, current_ff};
               OFS_SYST_CALIB: rd = CALIB_VALUE;
               OFS_ISER,
               OFS_ICER:       rd = en_ff;
               OFS_ISPR,
               OFS_ICPR:       rd = s1_ff.line_levels | soft_ff;
               OFS_CPUID:      rd = CPUID_VALUE;
               OFS_ICSR: begin
                  rd              = {23'd0, s1_ff.active_exception};
                  rd[31]          = pend_in[FLAG_NMI];
                  rd[28]          = pend_in[FLAG_PENDSV];
                  rd[26]          = pend_in[FLAG_TICK];
                  if (pend_lines != 32'd0) begin
                     rd[22]    = 1'b1;
                     rd[20:12] = IRQ_VECT_BASE + {4'd0, low_idx};
                  end
               end
               OFS_VTOR:       rd = {vtor_ff, 7'd0};
               OFS_AIRCR:      rd = AIRCR_VALUE;
               OFS_CCR:        rd = CCR_VALUE;
               OFS_SHPR2:      rd = {hprio_ff[0], 24'd0};
               OFS_SHPR3:      rd = {hprio_ff[2], hprio_ff[1], 16'd0};
               default: begin
                  // Bytes past the last priority entry shift in as zero
                  if (ipr_hit) begin
                     rd = 32'(prio_flat >> {ipr_base, 3'b000});
                  end
               end
            endcase
         end
         OP_WRITE: begin
            case (s1_ff.offset)
               OFS_SYST_CSR: begin
                  ctrl_in  = {1'b0, s1_ff.write_data[2:0]};
                  phase_in = '0;
               end
               OFS_SYST_RVR: begin
                  reload_in = s1_ff.write_data[TICK_WIDTH-1:0];
                  if (phase_ff > s1_ff.write_data[TICK_WIDTH-1:0]) begin
                     phase_in = '0;
                  end
               end
               OFS_SYST_CVR: begin
                  current_in          = '0;
                  ctrl_in[CTRL_COUNT] = 1'b0;
               end
               OFS_ISER: en_in   = en_ff | s1_ff.write_data;
               OFS_ICER: en_in   = en_ff & ~s1_ff.write_data;
               OFS_ISPR: soft_in = soft_ff | s1_ff.write_data;
               OFS_ICPR: soft_in = soft_ff & ~s1_ff.write_data;
               OFS_ICSR: begin
                  if (s1_ff.write_data[31]) pend_in[FLAG_NMI] = 1'b1;
                  if (s1_ff.write_data[28]) pend_in[FLAG_PENDSV] = 1'b1;
                  if (s1_ff.write_data[27]) pend_in[FLAG_PENDSV] = 1'b0;
                  if (s1_ff.write_data[26]) pend_in[FLAG_TICK] = 1'b1;
                  if (s1_ff.write_data[25]) pend_in[FLAG_TICK] = 1'b0;
               end
               OFS_VTOR:  vtor_in = s1_ff.write_data[31:7];
               OFS_AIRCR: begin
                  rst_req = s1_ff.write_data[2] && (s1_ff.write_data[31:16] == AIRCR_KEY);
               end
               OFS_SHPR2: hprio_in[0] = s1_ff.write_data[31:24];
               OFS_SHPR3: begin
                  hprio_in[1] = s1_ff.write_data[23:16];
                  hprio_in[2] = s1_ff.write_data[31:24];
               end
               default: begin
                  // Each priority byte takes its lane if it lies in the
                  // four bytes starting at the accessed offset.
                  for (int j = 0; j < IRQ_COUNT; j++) begin
                     diff = {1'b0, 5'(j)} - {1'b0, ipr_base};
                     if (ipr_hit && !diff[5] && (diff[4:2] == 3'd0)) begin
                        prio_in[j] = s1_ff.write_data[{diff[1:0], 3'b000} +: 8];
                     end
                  end
               end
            endcase
         end
         OP_TICK: begin
            if (ctrl_ff[CTRL_ENABLE] && (reload_ff != '0)) begin
               if (wrap) begin
                  phase_in            = '0;
                  ctrl_in[CTRL_COUNT] = 1'b1;
                  if (ctrl_ff[CTRL_TICKINT]) begin
                     pend_in[FLAG_TICK] = 1'b1;
                  end
               end else begin
                  phase_in = ph_inc;
               end
               current_in = reload_ff - phase_in;
            end
         end
         default: begin
         end
      endcase

      out_in.read_data          = rd;
      out_in.nmi_pending        = pend_in[FLAG_NMI];
      out_in.pendsv_pending     = pend_in[FLAG_PENDSV];
      out_in.systick_pending    = pend_in[FLAG_TICK];
      out_in.irq_active_pending = (s1_ff.line_levels | soft_in) & en_in;
      out_in.reset_request      = rst_req;
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         en_ff        <= '0;
         soft_ff      <= '0;
         for (int k = 0; k < IRQ_COUNT; k++) begin
            prio_ff[k] <= '0;
         end
         for (int k = 0; k < HANDLER_CNT; k++) begin
            hprio_ff[k] <= '0;
         end
         vtor_ff    <= '0;
         pend_ff    <= '0;
         ctrl_ff    <= '0;
         reload_ff  <= '0;
         current_ff <= '0;
         phase_ff   <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            en_ff        <= en_in;
            soft_ff      <= soft_in;
            prio_ff      <= prio_in;
            hprio_ff     <= hprio_in;
            vtor_ff      <= vtor_in;
            pend_ff      <= pend_in;
            ctrl_ff      <= ctrl_in;
            reload_ff    <= reload_in;
            current_ff   <= current_in;
            phase_ff     <= phase_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.opcode           <= req_chan.opcode;
         s1_ff.offset           <= req_chan.offset;
         s1_ff.write_data       <= req_chan.write_data;
         s1_ff.line_levels      <= req_chan.line_levels;
         s1_ff.active_exception <= req_chan.active_exception;
         s1_ff.pend_clear       <= req_chan.pend_clear;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ sim/armv6m_private_peripheral_bus_core_tb.sv @@
// Self-checking testbench for the NVIC, SCB and SysTick register block.
module armv6m_private_peripheral_bus_core_tb;
   import ppb_pkg::*;

   localparam int RANDOM_WORDS  = 774;
   localparam int STEADY_FIRST  = 300;   // random words without idling on either side
   localparam int STEADY_LAST   = 450;
   localparam int DRAIN_CYCLES  = 8;     // margin after the expected responses drain
   localparam int PRINT_CAP     = 100;

   // One row of the directed table. When typed is set, the expected response
   // is the one written in the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic        typed;
      opcode_type  opcode;
      logic [19:0] offset;
      logic [31:0] write_data;
      logic [31:0] line_levels;
      logic [8:0]  active_exception;
      logic [2:0]  pend_clear;
      logic [31:0] exp_read_data;
      logic [2:0]  exp_pend;      // bit 0 NMI, bit 1 PendSV, bit 2 SysTick
      logic [31:0] exp_irq;
      logic        exp_reset;
   } directed_row_type;

   localparam directed_row_type DIRECTED [26] = '{
      // fixed identification registers straight after reset
      '{1'b1, OP_READ, OFS_CPUID, 32'h0, 32'h0, 9'h0, 3'h0, CPUID_VALUE, 3'b000, 32'h0, 1'b0},
      '{1'b1, OP_READ, OFS_SYST_CALIB, 32'h0, 32'h0, 9'h0, 3'h0, CALIB_VALUE, 3'b000, 32'h0,
        1'b0},
      '{1'b1, OP_READ, OFS_AIRCR, 32'h0, 32'h0, 9'h0, 3'h0, AIRCR_VALUE, 3'b000, 32'h0, 1'b0},
      '{1'b1, OP_READ, OFS_CCR, 32'h0, 32'h0, 9'h0, 3'h0, CCR_VALUE, 3'b000, 32'h0, 1'b0},
      // all lines high but nothing enabled: pend register shows them, active mask stays zero
      '{1'b1, OP_READ, OFS_ISPR, 32'h0, 32'hFFFFFFFF, 9'h0, 3'h0, 32'hFFFFFFFF, 3'b000, 32'h0,
        1'b0},
      // keyed reset request, wrong key, key without SYSRESETREQ
      '{1'b1, OP_WRITE, OFS_AIRCR, 32'h05FA0004, 32'h0, 9'h0, 3'h0, 32'h0, 3'b000, 32'h0, 1'b1},
      '{1'b1, OP_WRITE, OFS_AIRCR, 32'hFA050004, 32'h0, 9'h0, 3'h0, 32'h0, 3'b000, 32'h0, 1'b0},
      '{1'b1, OP_WRITE, OFS_AIRCR, 32'h05FA0000, 32'h0, 9'h0, 3'h0, 32'h0, 3'b000, 32'h0, 1'b0},
      '{1'b1, OP_WRITE, OFS_ISER, 32'hFFFFFFFF, 32'h0, 9'h0, 3'h0, 32'h0, 3'b000, 32'h0, 1'b0},
      '{1'b1, OP_WRITE, OFS_ISPR, 32'h80000000, 32'h0, 9'h0, 3'h0, 32'h0, 3'b000, 32'h80000000,
        1'b0},
      // ICSR with the highest line pending and the widest active exception number
      '{1'b1, OP_READ, OFS_ICSR, 32'h0, 32'h0, 9'h1FF, 3'h0, 32'h0042F1FF, 3'b000, 32'h80000000,
        1'b0},
      // set all three pends, then clear them by write and by acknowledge together
      '{1'b1, OP_WRITE, OFS_ICSR, 32'h94000000, 32'h0, 9'h0, 3'h0, 32'h0, 3'b111, 32'h80000000,
        1'b0},
      '{1'b1, OP_WRITE, OFS_ICSR, 32'h0A000000, 32'h0, 9'h0, 3'h1, 32'h0, 3'b000, 32'h80000000,
        1'b0},
      '{1'b0, OP_WRITE, OFS_VTOR, 32'hFFFFFFFF, 32'h55555555, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0,
        1'b0},
      '{1'b1, OP_READ, OFS_VTOR, 32'h0, 32'h0, 9'h0, 3'h0, 32'hFFFFFF80, 3'b000, 32'h80000000,
        1'b0},
      // unaligned priority access running off the end of the priority window
      '{1'b0, OP_WRITE, OFS_IPR_BASE + 20'h1D, 32'hAABBCCDD, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0,
        32'h0, 1'b0},
      '{1'b0, OP_READ, OFS_IPR_BASE + 20'h1C, 32'h0, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_WRITE, OFS_SHPR3, 32'hFFFF0000, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_READ, OFS_SHPR3, 32'h0, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      // SysTick: reload of two, enable with interrupt, three ticks reach the wrap
      '{1'b0, OP_WRITE, OFS_SYST_RVR, 32'hFF000002, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0,
        1'b0},
      '{1'b0, OP_WRITE, OFS_SYST_CSR, 32'hFFFFFFFF, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_TICK, 20'h0, 32'h0, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_TICK, 20'h0, 32'h0, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_TICK, 20'h0, 32'h0, 32'hFFFFFFFF, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      // COUNTFLAG read clears it; a no-op word then acknowledges the SysTick pend
      '{1'b0, OP_READ, OFS_SYST_CSR, 32'h0, 32'h0, 9'h0, 3'h0, 32'h0, 3'b0, 32'h0, 1'b0},
      '{1'b0, OP_NOP, OFS_SYST_CSR, 32'hFFFFFFFF, 32'hFFFFFFFF, 9'h1FF, 3'h4, 32'h0, 3'b0, 32'h0,
        1'b0}
   };

   localparam logic [19:0] MAPPED_OFFSETS [17] = '{
      OFS_SYST_CSR, OFS_SYST_RVR, OFS_SYST_CVR, OFS_SYST_CALIB, OFS_ISER, OFS_ICER, OFS_ISPR,
      OFS_ICPR, OFS_IPR_BASE, OFS_CPUID, OFS_ICSR, OFS_VTOR, OFS_AIRCR, OFS_CCR, OFS_SHPR2,
      OFS_SHPR3, OFS_IPR_BASE + 20'h1C
   };

   logic clock = 1'b0;
   logic reset;
   logic drain_ready;
   logic no_idle = 1'b0;

   ppb_req_if req_bus ();
   ppb_rsp_if rsp_bus ();

   armv6m_private_peripheral_bus_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   assign rsp_bus.ready = drain_ready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the register block, advanced once per accepted request word.
   logic [31:0] en_mask;
   logic [31:0] swpend_mask;
   logic [7:0]  irq_prio [IRQ_COUNT];
   logic [7:0]  sys_prio [HANDLER_CNT];     // SVCall, PendSV, SysTick
   logic [24:0] vtor_bits;
   logic [2:0]  pend_bits;
   logic [3:0]  syst_ctrl;
   logic [23:0] syst_reload;
   logic [23:0] syst_current;
   logic [23:0] syst_phase;

   rsp_word_type pending_rsp_words [$];

   int unsigned mismatch_count;
   int unsigned checked_count;
   int unsigned read_count;
   int unsigned write_count;
   int unsigned tick_count;
   int unsigned wrap_count;
   int unsigned reset_req_count;

   // Compute the response word for one request word and advance the shadow state.
   function automatic rsp_word_type predict_ppb_response(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  live;
      logic [8:0]   lowest;
      int unsigned  base;
      r = '0;
      pend_bits &= ~w.pend_clear;   // acknowledges land before the operation
      case (w.opcode)
         OP_READ: begin
            read_count++;
            case (w.offset)
               OFS_SYST_CSR: begin
                  r.read_data = {15'h0, syst_ctrl[CTRL_COUNT], 13'h0, syst_ctrl[2:0]};
                  syst_ctrl[CTRL_COUNT] = 1'b0;
               end
               OFS_SYST_RVR:   r.read_data = {8'h0, syst_reload};
               OFS_SYST_CVR:   r.read_data = {8'h0, syst_current};
               OFS_SYST_CALIB: r.read_data = CALIB_VALUE;
               OFS_ISER, OFS_ICER: r.read_data = en_mask;
               OFS_ISPR, OFS_ICPR: r.read_data = w.line_levels | swpend_mask;
               OFS_CPUID:      r.read_data = CPUID_VALUE;
               OFS_ICSR: begin
                  r.read_data = {23'h0, w.active_exception};
                  r.read_data[31] = pend_bits[FLAG_NMI];
                  r.read_data[28] = pend_bits[FLAG_PENDSV];
                  r.read_data[26] = pend_bits[FLAG_TICK];
                  live = (w.line_levels | swpend_mask) & en_mask;
                  if (live != 32'h0) begin
                     lowest = 9'h0;
                     for (int b = 31; b >= 0; b--)
                        if (live[b]) lowest = 9'(b);
                     r.read_data[22] = 1'b1;
                     r.read_data[20:12] = IRQ_VECT_BASE + lowest;
                  end
               end
               OFS_VTOR:  r.read_data = {vtor_bits, 7'h0};
               OFS_AIRCR: r.read_data = AIRCR_VALUE;
               OFS_CCR:   r.read_data = CCR_VALUE;
               OFS_SHPR2: r.read_data = {sys_prio[0], 24'h0};
               OFS_SHPR3: r.read_data = {sys_prio[2], sys_prio[1], 16'h0};
               default: begin
                  if (w.offset >= OFS_IPR_BASE && w.offset < OFS_IPR_END) begin
                     base = w.offset - OFS_IPR_BASE;
                     for (int k = 0; k < 4; k++)
                        if (base + k < IRQ_COUNT) r.read_data[8*k +: 8] = irq_prio[base + k];
                  end
               end
            endcase
         end
         OP_WRITE: begin
            write_count++;
            case (w.offset)
               OFS_SYST_CSR: begin
                  syst_ctrl  = {1'b0, w.write_data[2:0]};
                  syst_phase = '0;
               end
               OFS_SYST_RVR: begin
                  syst_reload = w.write_data[23:0];
                  if (syst_phase > syst_reload) syst_phase = '0;
               end
               OFS_SYST_CVR: begin
                  syst_current = '0;
                  syst_ctrl[CTRL_COUNT] = 1'b0;
               end
               OFS_ISER: en_mask |= w.write_data;
               OFS_ICER: en_mask &= ~w.write_data;
               OFS_ISPR: swpend_mask |= w.write_data;
               OFS_ICPR: swpend_mask &= ~w.write_data;
               OFS_ICSR: begin
                  // set before clear, so a word with both clears the flag
                  if (w.write_data[31]) pend_bits[FLAG_NMI] = 1'b1;
                  if (w.write_data[28]) pend_bits[FLAG_PENDSV] = 1'b1;
                  if (w.write_data[27]) pend_bits[FLAG_PENDSV] = 1'b0;
                  if (w.write_data[26]) pend_bits[FLAG_TICK] = 1'b1;
                  if (w.write_data[25]) pend_bits[FLAG_TICK] = 1'b0;
               end
               OFS_VTOR:  vtor_bits = w.write_data[31:7];
               OFS_AIRCR: r.reset_request = w.write_data[2] && w.write_data[31:16] == AIRCR_KEY;
               OFS_SHPR2: sys_prio[0] = w.write_data[31:24];
               OFS_SHPR3: begin
                  sys_prio[1] = w.write_data[23:16];
                  sys_prio[2] = w.write_data[31:24];
               end
               default: begin
                  if (w.offset >= OFS_IPR_BASE && w.offset < OFS_IPR_END) begin
                     base = w.offset - OFS_IPR_BASE;
                     for (int k = 0; k < 4; k++)
                        if (base + k < IRQ_COUNT) irq_prio[base + k] = w.write_data[8*k +: 8];
                  end
               end
            endcase
         end
         OP_TICK: begin
            tick_count++;
            if (syst_ctrl[CTRL_ENABLE] && syst_reload != '0) begin
               syst_phase = syst_phase + 24'd1;
               if ({1'b0, syst_phase} >= {1'b0, syst_reload} + 25'd1 || syst_phase == '0) begin
                  syst_phase = '0;
                  syst_ctrl[CTRL_COUNT] = 1'b1;
                  if (syst_ctrl[CTRL_TICKINT]) pend_bits[FLAG_TICK] = 1'b1;
                  wrap_count++;
               end
               syst_current = syst_reload - syst_phase;
            end
         end
         default: ;
      endcase
      if (r.reset_request) reset_req_count++;
      r.nmi_pending        = pend_bits[FLAG_NMI];
      r.pendsv_pending     = pend_bits[FLAG_PENDSV];
      r.systick_pending    = pend_bits[FLAG_TICK];
      r.irq_active_pending = (w.line_levels | swpend_mask) & en_mask;
      return r;
   endfunction

   // Build one random request word, weighted toward mapped registers and small reloads
   // so that the SysTick counter wraps often.
   function automatic req_word_type random_ppb_word();
      req_word_type w;
      int unsigned  roll;
      roll = $urandom_range(99);
      if (roll < 30)      w.opcode = OP_TICK;
      else if (roll < 62) w.opcode = OP_WRITE;
      else if (roll < 97) w.opcode = OP_READ;
      else                w.opcode = OP_NOP;

      roll = $urandom_range(99);
      if (roll < 80)      w.offset = MAPPED_OFFSETS[$urandom_range(16)];
      else if (roll < 93) w.offset = OFS_IPR_BASE + 20'($urandom_range(31));
      else                w.offset = 20'($urandom);

      w.write_data = $urandom;
      roll = $urandom_range(99);
      if (w.offset == OFS_SYST_RVR && roll < 80)
         w.write_data = (w.write_data & 32'hFF000000) | 32'($urandom_range(7));
      else if (w.offset == OFS_SYST_RVR && roll < 90)
         w.write_data = w.write_data | 32'h00FFFFFF;
      else if (w.offset == OFS_AIRCR && roll < 50)
         w.write_data = {AIRCR_KEY, w.write_data[15:0]};

      roll = $urandom_range(2);
      if (roll == 0)      w.line_levels = '0;
      else if (roll == 1) w.line_levels = 32'h1 << $urandom_range(31);
      else                w.line_levels = $urandom;

      w.active_exception = 9'($urandom_range(511));
      w.pend_clear = ($urandom_range(99) < 70) ? 3'h0 : 3'($urandom_range(7));
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Present one request word from a falling edge, hold it until accepted, then
   // queue its expected response. A typed row overrides the predicted response,
   // but the shadow state always advances.
   task automatic send_word(input req_word_type w, input logic typed, input rsp_word_type fixed);
      rsp_word_type predicted;
      while (!no_idle && $urandom_range(99) < 25) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid            = 1'b1;
      req_bus.opcode           = w.opcode;
      req_bus.offset           = w.offset;
      req_bus.write_data       = w.write_data;
      req_bus.line_levels      = w.line_levels;
      req_bus.active_exception = w.active_exception;
      req_bus.pend_clear       = w.pend_clear;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_ppb_response(w);
      pending_rsp_words.push_back(typed ? fixed : predicted);
      @(negedge clock);
   endtask

   // Drive the response ready: idle about a quarter of the cycles, none in the steady stretch.
   always @(negedge clock) drain_ready = no_idle || ($urandom_range(99) >= 25);

   // Compare every accepted response word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_words.size() == 0) begin
            report_mismatch("response word with nothing expected", rsp_bus.read_data, 32'h0);
         end else begin
            want = pending_rsp_words.pop_front();
            checked_count++;
            if (rsp_bus.read_data !== want.read_data)
               report_mismatch("read_data", rsp_bus.read_data, want.read_data);
            if (rsp_bus.nmi_pending !== want.nmi_pending)
               report_mismatch("nmi_pending", 32'(rsp_bus.nmi_pending), 32'(want.nmi_pending));
            if (rsp_bus.pendsv_pending !== want.pendsv_pending)
               report_mismatch("pendsv_pending", 32'(rsp_bus.pendsv_pending),
                               32'(want.pendsv_pending));
            if (rsp_bus.systick_pending !== want.systick_pending)
               report_mismatch("systick_pending", 32'(rsp_bus.systick_pending),
                               32'(want.systick_pending));
            if (rsp_bus.irq_active_pending !== want.irq_active_pending)
               report_mismatch("irq_active_pending", rsp_bus.irq_active_pending,
                               want.irq_active_pending);
            if (rsp_bus.reset_request !== want.reset_request)
               report_mismatch("reset_request", 32'(rsp_bus.reset_request),
                               32'(want.reset_request));
         end
      end
   end

   initial begin
      req_word_type     w;
      rsp_word_type     fixed;
      directed_row_type row;

      // Hold the inputs at known values and clear the shadow state.
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.opcode           = OP_READ;
      req_bus.offset           = '0;
      req_bus.write_data       = '0;
      req_bus.line_levels      = '0;
      req_bus.active_exception = '0;
      req_bus.pend_clear       = '0;
      en_mask      = '0;
      swpend_mask  = '0;
      vtor_bits    = '0;
      pend_bits    = '0;
      syst_ctrl    = '0;
      syst_reload  = '0;
      syst_current = '0;
      syst_phase   = '0;
      foreach (irq_prio[i]) irq_prio[i] = '0;
      foreach (sys_prio[i]) sys_prio[i] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      for (int i = 0; i < $size(DIRECTED); i++) begin
         row = DIRECTED[i];
         w = '{row.opcode, row.offset, row.write_data, row.line_levels, row.active_exception,
               row.pend_clear};
         fixed = '{row.exp_read_data, row.exp_pend[0], row.exp_pend[1], row.exp_pend[2],
                   row.exp_irq, row.exp_reset};
         send_word(w, row.typed, fixed);
      end

      // Random words, with one stretch where neither side idles.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         no_idle = (i >= STEADY_FIRST && i < STEADY_LAST);
         send_word(random_ppb_word(), 1'b0, '0);
      end
      no_idle = 1'b0;
      req_bus.valid = 1'b0;

      // Drain, then keep watching the response channel for any stray word.
      while (pending_rsp_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d response words: %0d reads, %0d writes, %0d ticks",
               checked_count, read_count, write_count, tick_count);
      $display("counter wraps %0d, reset requests %0d, mismatches %0d",
               wrap_count, reset_req_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #3_000_000;
      $display("timeout with %0d response words outstanding", pending_rsp_words.size());
      $display("simulation failed");
      $finish;
   end

endmodule
